// File: rtl/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, constants and helpers of the scrolling segment message block.
// ----------------------------------------------------------------------------
package ssm_pkg;

	localparam int DIGIT_COUNT_DEF   = 8;
	localparam int MESSAGE_DEPTH_DEF = 256;

	localparam int SEG_W    = 8;   // one segment bitmap
	localparam int POS_W    = 8;   // position field and scroll position
	localparam int IDX_W    = 9;   // character index, reaches the length itself
	localparam int LEN_W    = 9;   // message length, 0 to 256
	localparam int DELAY_W  = 8;
	localparam int DIGIT_W  = 3;
	localparam int SPEED_W  = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = 8;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 24;

	// request kinds carried on tuser
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_SPEED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_STEP    = 1'd1;

	// segments that move across in a half-digit step
	localparam logic [SEG_W-1:0] SEG_L_HI = 8'h20;
	localparam logic [SEG_W-1:0] SEG_L_LO = 8'h10;
	localparam logic [SEG_W-1:0] SEG_R_LO = 8'h02;
	localparam logic [SEG_W-1:0] SEG_R_HI = 8'h04;

	typedef struct packed {
		logic               start;
		logic               half;
		logic [IDX_W-1:0]   start_idx;
		logic [LEN_W-1:0]   length;
		logic [DELAY_W-1:0] delay;
	} frame_cmd_t;

	typedef struct packed {
		logic               frame_end;
		logic [DELAY_W-1:0] next_delay;
		logic [SEG_W-1:0]   digit_segments;
		logic [DIGIT_W-1:0] digit;
	} result_t;

	// right half of the left character joined with the left half of the next
	function automatic logic [SEG_W-1:0] half_merge(input logic [SEG_W-1:0] l,
	                                                input logic [SEG_W-1:0] r);
		half_merge = ((l & SEG_L_HI) >> 4) | ((l & SEG_L_LO) >> 2)
		           | ((r & SEG_R_LO) << 4) | ((r & SEG_R_HI) << 2);
	endfunction

endpackage

// File: rtl/ssm_ram.sv
// ----------------------------------------------------------------------------
// ssm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ssm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/ssm_frame.sv
// ----------------------------------------------------------------------------
// ssm_frame
// Frame sequencer: walks the message store one character a cycle while the
// output is not stalled, and emits one digit bitmap per character after the first.
// ----------------------------------------------------------------------------
module ssm_frame #(
	parameter int DIGIT_COUNT = ssm_pkg::DIGIT_COUNT_DEF,
	parameter int AW = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ssm_pkg::frame_cmd_t        cmd,
	output logic                       busy,
	output logic                       rd_en,
	output logic [AW-1:0]              rd_addr,
	input  logic [ssm_pkg::SEG_W-1:0]  rd_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output ssm_pkg::result_t           out_res
);

	import ssm_pkg::*;

	localparam int CW = $clog2(DIGIT_COUNT + 1);

	logic             busy_q;
	logic             blank_q;
	logic [CW-1:0]    cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic [SEG_W-1:0] prev_q;
	logic             out_valid_q;
	result_t          out_res_q;

	logic             slot_free;
	logic             consume;
	logic             last_chr;
	logic [SEG_W-1:0] chr;
	logic [IDX_W-1:0] idx_inc;
	logic [IDX_W-1:0] idx_nxt;

	assign slot_free = !out_valid_q || out_ready;
	assign chr       = blank_q ? '0 : rd_data;
	// the first character only primes the previous-character register
	assign consume   = busy_q && ((cnt_q == '0) || slot_free);
	assign last_chr  = (cnt_q == CW'(DIGIT_COUNT));
	assign idx_inc   = idx_q + IDX_W'(1);
	assign idx_nxt   = (idx_inc >= cmd.length) ? '0 : idx_inc;

	assign rd_en   = cmd.start || (consume && !last_chr);
	assign rd_addr = cmd.start ? AW'(cmd.start_idx) : AW'(idx_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (consume) begin
				if (last_chr) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			if (consume && (cnt_q != '0)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			idx_q   <= cmd.start_idx;
			blank_q <= (cmd.start_idx >= cmd.length);
		end else if (consume && !last_chr) begin
			idx_q   <= idx_nxt;
			blank_q <= (idx_nxt >= cmd.length);
		end
		if (consume) begin
			prev_q <= chr;
		end
		if (consume && (cnt_q != '0)) begin
			out_res_q.digit          <= DIGIT_W'(cnt_q - CW'(1));
			out_res_q.digit_segments <= cmd.half ? half_merge(prev_q, chr) : prev_q;
			out_res_q.next_delay     <= cmd.delay;
			out_res_q.frame_end      <= last_chr;
		end
	end

	assign busy      = busy_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

// File: rtl/scrolling_segment_message.sv
// ----------------------------------------------------------------------------
// scrolling_segment_message
// Scrolls a message of seven-segment bitmaps across a row of digits.
// ----------------------------------------------------------------------------
// Usage
//   s_* channel takes requests. tuser 0 is a load: the bitmap in tdata is
//   written to the message store at the given position (positions at or past
//   MESSAGE_DEPTH are dropped). A load with tlast sets the length to
//   position + 1 and emits one frame. tuser 1 is a scroll tick: it works out
//   the delay to the next tick, steps the scroll position and emits a frame.
//   A frame is DIGIT_COUNT results on m_*, digit 0 first, tlast on the last.
//   cfg_* writes scroll_speed (index 0) and half_step_mode (index 1); write
//   only while no frame is under way.
// Timing
//   A load without tlast leaves s_tready high. A frame request holds s_tready
//   low while the command is handed over and the walk runs: one store read per
//   character, DIGIT_COUNT + 1 of them, through the single read port of the
//   message RAM.
// Reset and stalls
//   Reset clears length, position, half step and both registers; the store
//   keeps no reset, so an empty message shows blank digits. While m_tready
//   is low the result register holds and the character walk stalls with it;
//   a new request is taken while the last result of a frame still waits.
// ----------------------------------------------------------------------------
module scrolling_segment_message #(
	parameter int DIGIT_COUNT   = ssm_pkg::DIGIT_COUNT_DEF,
	parameter int MESSAGE_DEPTH = ssm_pkg::MESSAGE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ssm_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] position, [15:8] segments
	input  logic                            s_tuser,   // [0] req_type
	input  logic                            s_tlast,   // last_entry
	// result channel
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ssm_pkg::M_TDATA_W-1:0]   m_tdata,   // [2:0] digit, [10:3] digit_segments,
	                                                   // [18:11] next_delay, [23:19] zero
	output logic                            m_tlast,   // frame_end
	// configuration write port
	input  logic                            cfg_we,
	input  logic [ssm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ssm_pkg::CFG_W-1:0]       cfg_data
);

	import ssm_pkg::*;

	localparam int AW = $clog2(MESSAGE_DEPTH);

	// configuration
	logic [SPEED_W-1:0] speed_q;
	logic               hmode_q;

	// scroll state
	logic [LEN_W-1:0]   len_q;
	logic [POS_W-1:0]   pos_q;
	logic               half_q;
	logic [DELAY_W-1:0] delay_q;
	logic               start_q;

	logic               accept;
	logic               is_load;
	logic [POS_W-1:0]   req_pos;
	logic [SEG_W-1:0]   req_seg;
	logic               pos_ok;
	logic [LEN_W-1:0]   new_len;
	logic [LEN_W-1:0]   pos_inc;
	logic [POS_W-1:0]   pos_next;
	logic [9:0]         speed_x3;
	logic [DELAY_W-1:0] tick_delay;

	frame_cmd_t         cmd;
	logic               frame_busy;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [SEG_W-1:0]   rd_data;
	logic               wr_en;
	result_t            res;

	assign req_pos = s_tdata[POS_W-1:0];
	assign req_seg = s_tdata[POS_W +: SEG_W];
	assign is_load = (s_tuser == REQ_LOAD);

	// no new request while a frame command waits or the walk is running
	assign s_tready = !start_q && !frame_busy;
	assign accept   = s_tvalid && s_tready;

	assign pos_ok  = (32'(req_pos) < MESSAGE_DEPTH);
	assign new_len = {1'b0, req_pos} + LEN_W'(1);
	assign wr_en   = accept && is_load && pos_ok;

	// next character index, wrapping at the length
	assign pos_inc  = {1'b0, pos_q} + LEN_W'(1);
	assign pos_next = (pos_inc >= len_q) ? '0 : pos_inc[POS_W-1:0];

	// full step: speed; half step: a quarter on the way in, three quarters out
	assign speed_x3 = {2'b00, speed_q} + {1'b0, speed_q, 1'b0};
	always_comb begin
		if (speed_q == '0) begin
			tick_delay = '0;
		end else if (!hmode_q) begin
			tick_delay = speed_q;
		end else if (half_q) begin
			tick_delay = speed_x3[9:2];
		end else begin
			tick_delay = speed_q >> 2;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
			hmode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCROLL_SPEED: speed_q <= cfg_data;
				REG_HALF_STEP:    hmode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// apply the request to the scroll state, then launch the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			pos_q   <= '0;
			half_q  <= 1'b0;
			delay_q <= '0;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (accept) begin
				if (is_load) begin
					if (pos_ok && s_tlast) begin
						len_q   <= new_len;
						delay_q <= '0;
						start_q <= 1'b1;
						// drop back to the start only if past the new end
						if ({1'b0, pos_q} > new_len) begin
							pos_q  <= '0;
							half_q <= 1'b0;
						end
					end
				end else begin
					delay_q <= tick_delay;
					start_q <= 1'b1;
					if (speed_q != '0) begin
						if (len_q > LEN_W'(DIGIT_COUNT)) begin
							if (half_q || !hmode_q) begin
								half_q <= 1'b0;
								pos_q  <= pos_next;
							end else begin
								half_q <= 1'b1;
							end
						end else begin
							// message fits the display: hold it still
							pos_q  <= '0;
							half_q <= 1'b0;
						end
					end
				end
			end
		end
	end

	assign cmd.start     = start_q;
	assign cmd.half      = half_q;
	assign cmd.start_idx = {1'b0, pos_q};
	assign cmd.length    = len_q;
	assign cmd.delay     = delay_q;

	ssm_ram #(
		.WIDTH (SEG_W),
		.DEPTH (MESSAGE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(req_pos)),
		.wr_data (req_seg),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ssm_frame #(
		.DIGIT_COUNT (DIGIT_COUNT),
		.AW          (AW)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.busy      (frame_busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {5'b00000, res.next_delay, res.digit_segments, res.digit};
	assign m_tlast = res.frame_end;

endmodule

// File: rtl/ssm_checker.sv
// ----------------------------------------------------------------------------
// ssm_checker
// Port-level checks of the scrolling segment message block, bound to it.
// ----------------------------------------------------------------------------
module ssm_checker #(
	parameter int DIGIT_COUNT = ssm_pkg::DIGIT_COUNT_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          s_tuser,
	input logic                          s_tlast,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ssm_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tlast
);

	import ssm_pkg::*;

	// a tick always launches a frame, so the next request must wait
	a_tick_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == REQ_TICK) |=> !s_tready)
		else $error("request taken right after a scroll tick");

	// a plain load writes the store and frees the channel at once
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == REQ_LOAD) && !s_tlast |=> s_tready)
		else $error("load without last mark stalled the request channel");

	// frame end sits on the rightmost digit
	a_end_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[DIGIT_W-1:0] == DIGIT_W'(DIGIT_COUNT - 1)))
		else $error("frame end on the wrong digit");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

endmodule

bind scrolling_segment_message ssm_checker #(
	.DIGIT_COUNT (DIGIT_COUNT)
) u_ssm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// File: sim/scrolling_segment_message_tb.sv
// ----------------------------------------------------------------------------
// scrolling_segment_message_tb
// Drives load and tick requests into the scrolling segment message block and
// checks every digit result against a cycle-free prediction of each frame.
// The run covers short, long and full-store messages, both step modes and a
// spread of scroll speeds, with sender and receiver idling at random.
// ----------------------------------------------------------------------------

// Predicts the frames of the block and holds the digits still to arrive.
class scroll_frame_board;
	bit [7:0]         chars [256];
	int unsigned      msg_len;
	int unsigned      scroll_pos;
	bit               half;
	int unsigned      speed;
	bit               half_mode;
	ssm_pkg::result_t pending_digits [$];
	int               errors;
	int               frames;
	int               digits_checked;

	function void set_regs(int unsigned new_speed, bit new_half);
		speed     = new_speed;
		half_mode = new_half;
	endfunction

	// wrap to the start once the index reaches the length
	function int unsigned step_index(int unsigned i);
		return (i + 1 >= msg_len) ? 0 : i + 1;
	endfunction

	// an index at or past the length shows blank
	function bit [7:0] char_at(int unsigned i);
		return (i >= msg_len) ? 8'h00 : chars[i];
	endfunction

	function void push_frame(int unsigned delay);
		int unsigned      si;
		int unsigned      ni;
		int               d;
		bit [7:0]         l;
		bit [7:0]         r;
		bit [7:0]         bm;
		ssm_pkg::result_t e;
		si = scroll_pos;
		for (d = 0; d < ssm_pkg::DIGIT_COUNT_DEF; d++) begin
			ni = step_index(si);
			if (half) begin
				// right-hand segments of this character, left-hand of the next
				l     = char_at(si);
				r     = char_at(ni);
				bm    = 8'h00;
				bm[1] = l[5];
				bm[2] = l[4];
				bm[5] = r[1];
				bm[4] = r[2];
			end else begin
				bm = char_at(si);
			end
			e.digit          = d[ssm_pkg::DIGIT_W-1:0];
			e.digit_segments = bm;
			e.next_delay     = delay[ssm_pkg::DELAY_W-1:0];
			e.frame_end      = (d == ssm_pkg::DIGIT_COUNT_DEF - 1);
			pending_digits.push_back(e);
			si = ni;
		end
		frames++;
	endfunction

	function void note_request(logic req, logic [7:0] pos, logic [7:0] seg, logic last);
		int unsigned delay;
		if (req == ssm_pkg::REQ_LOAD) begin
			if (pos >= ssm_pkg::MESSAGE_DEPTH_DEF)
				return;
			chars[pos] = seg;
			if (!last)
				return;
			msg_len = pos + 1;
			if (scroll_pos > msg_len) begin
				scroll_pos = 0;
				half       = 1'b0;
			end
			push_frame(0);
			return;
		end
		delay = 0;
		if (speed != 0) begin
			if (!half_mode)
				delay = speed;
			else if (half)
				delay = (3 * speed) >> 2;
			else
				delay = speed >> 2;
			if (msg_len > ssm_pkg::DIGIT_COUNT_DEF) begin
				if (half || !half_mode) begin
					half       = 1'b0;
					scroll_pos = step_index(scroll_pos) & 8'hFF;
				end else begin
					half = 1'b1;
				end
			end else begin
				scroll_pos = 0;
				half       = 1'b0;
			end
		end
		push_frame(delay);
	endfunction

	function void compare(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$error("%s: expected 'h%0h, got 'h%0h", field, want, got);
		end
	endfunction

	function void check_digit(logic [ssm_pkg::M_TDATA_W-1:0] tdata, logic tlast);
		ssm_pkg::result_t e;
		if (pending_digits.size() == 0) begin
			errors++;
			$error("digit: expected none, got %0d", tdata[2:0]);
			return;
		end
		e = pending_digits.pop_front();
		compare("digit", e.digit, tdata[2:0]);
		compare("digit_segments", e.digit_segments, tdata[10:3]);
		compare("next_delay", e.next_delay, tdata[18:11]);
		compare("frame_end", e.frame_end, tlast);
		compare("tdata padding", 0, tdata[23:19]);
		digits_checked++;
	endfunction
endclass

module scrolling_segment_message_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ssm_pkg::*;

	// cycles with no handshake on either side before the run is abandoned
	localparam int QUIET_LIMIT    = 4000;
	// a frame request keeps the block busy until its walk ends; this margin
	// covers any tail after the last predicted digit
	localparam int SETTLE_CYCLES  = 16;
	localparam int PHASE_REQUESTS = 22;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [7:0] position, [15:8] segments
	logic                  s_tuser   = 1'b0; // [0] req_type
	logic                  s_tlast   = 1'b0; // last_entry
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;          // [2:0] digit, [10:3] digit_segments,
	                                         // [18:11] next_delay, [23:19] zero
	logic                  m_tlast;          // frame_end
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data  = '0;

	int                    tx_idle_pct = 24;
	int                    rx_idle_pct = 61;
	int                    quiet_cycles = 0;
	int                    loads_sent = 0;
	int                    ticks_sent = 0;
	bit                    stored [256];     // entries written since reset
	scroll_frame_board     board;

	scrolling_segment_message dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: stall at random at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Check every digit taken by the receiver against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_digit(m_tdata, m_tlast);
	end

	// Watchdog: abandon the run once nothing has moved for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one request, idling first at the sender's rate, and hold it
	// until the block takes it. Valid stays high on return so that a request
	// following straight after goes out back to back.
	task automatic send(logic req, logic [7:0] pos, logic [7:0] seg, logic last);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {seg, pos};
		s_tlast  <= last;
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		board.note_request(req, pos, seg, last);
		if (req == REQ_LOAD) begin
			stored[pos] = 1'b1;
			loads_sent++;
		end else begin
			ticks_sent++;
		end
	endtask

	// A tick ignores position, segments and the last mark: fill them with noise.
	task automatic tick();
		send(REQ_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
		     1'($urandom_range(0, 1)));
	endtask

	// Write a whole message from entry 0 with random bitmaps, last mark at the end.
	task automatic load_message(int len);
		int p;
		for (p = 0; p < len; p++)
			send(REQ_LOAD, p[7:0], 8'($urandom_range(0, 255)), p == len - 1);
	endtask

	// Drop valid, wait for every predicted digit, then let the tail pass.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.pending_digits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers on consecutive cycles; only call while settled.
	task automatic configure(int speed, bit half);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SCROLL_SPEED;
		cfg_data  <= speed[CFG_W-1:0];
		@(posedge clk);
		cfg_index <= REG_HALF_STEP;
		cfg_data  <= {{(CFG_W-1){1'b0}}, half};
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		board.set_regs(speed, half);
	endtask

	// Favour the extremes and the speeds where the quarter delays round to zero.
	function automatic int pick_speed();
		case ($urandom_range(0, 5))
			0: begin
				return 0;
			end
			1: begin
				return 1;
			end
			2: begin
				return 255;
			end
			3: begin
				return 4;
			end
			default: begin
				return $urandom_range(2, 254);
			end
		endcase
	endfunction

	// Number of entries written without a gap from entry 0; a last-marked load
	// beyond that would make frames read entries never written.
	function automatic int written_prefix();
		int n;
		n = 0;
		while (n < 256 && stored[n])
			n++;
		return n;
	endfunction

	initial begin
		int phase;
		int start;
		int epoch_left;
		int pick;
		int len;
		int mark;
		int p;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// Empty message straight after reset: blank digits, speed 0, no delay.
		tick();
		// One-character message, all segments lit.
		send(REQ_LOAD, 8'd0, 8'hFF, 1'b1);
		// Ten characters, the last one blank: long enough to scroll.
		for (p = 1; p < 10; p++)
			send(REQ_LOAD, p[7:0], (p == 9) ? 8'h00 : 8'($urandom_range(0, 255)), p == 9);
		settle();
		configure(255, 1'b0);
		tick();
		tick();
		// Half steps from position 2: quarter delay, then three quarters.
		settle();
		configure(255, 1'b1);
		tick();
		tick();
		tick();
		// Shorten to three characters with the position sitting on the length:
		// position is kept, the character there reads blank.
		send(REQ_LOAD, 8'd2, 8'($urandom_range(0, 255)), 1'b1);
		// Message no longer than the display: position and half step clear.
		tick();
		// Back to ten characters, scroll to position 2, then cut to one
		// character so that the position lies past the new length.
		send(REQ_LOAD, 8'd9, 8'($urandom_range(0, 255)), 1'b1);
		repeat (4) tick();
		send(REQ_LOAD, 8'd0, 8'($urandom_range(0, 255)), 1'b1);

		// ---- random part ----
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 24;
					rx_idle_pct = 61;
				end
				1: begin
					tx_idle_pct = 61;
					rx_idle_pct = 24;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			if (phase == 2) begin
				// Fill the whole store once: length reaches its full 256.
				settle();
				configure(pick_speed(), 1'($urandom_range(0, 1)));
				load_message(256);
				repeat (6) tick();
			end
			start      = loads_sent + ticks_sent;
			epoch_left = 0;
			while (loads_sent + ticks_sent - start < PHASE_REQUESTS) begin
				if (epoch_left <= 0) begin
					// pause the sender until the block has drained, then retune
					settle();
					configure(pick_speed(), 1'($urandom_range(0, 1)));
					epoch_left = $urandom_range(15, 30);
				end
				mark = loads_sent + ticks_sent;
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					// well-formed message, mostly just longer than the display
					case ($urandom_range(0, 9))
						0, 1: begin
							len = $urandom_range(1, 8);
						end
						2: begin
							len = $urandom_range(20, 40);
						end
						default: begin
							len = $urandom_range(9, 14);
						end
					endcase
					load_message(len);
				end else if (pick < 75) begin
					repeat ($urandom_range(1, 16)) tick();
				end else if (pick < 88) begin
					// move the end mark anywhere inside the written prefix or just past its end
					len = written_prefix();
					if (len > 255)
						len = 255;
					send(REQ_LOAD, 8'($urandom_range(0, len)), 8'($urandom_range(0, 255)),
					     1'b1);
				end else begin
					// stray loads with no end mark: stored, no frame
					repeat ($urandom_range(1, 4))
						send(REQ_LOAD, 8'($urandom_range(0, 255)),
						     8'($urandom_range(0, 255)), 1'b0);
				end
				epoch_left -= loads_sent + ticks_sent - mark;
			end
		end

		settle();
		$display("covered %0d requests (%0d loads, %0d ticks); %0d digits checked in %0d frames",
		         loads_sent + ticks_sent, loads_sent, ticks_sent, board.digits_checked,
		         board.frames);
		$display("speeds 0 to 255 in whole and half steps, messages from 1 to 256 characters");
		if (board.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
